// ===== rtl/fpc_pkg.sv =====
// shared types, widths and register codes of the feedforward peak compressor
`default_nettype none

package fpc_pkg;

    localparam int CHANNELS = 2;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int SAMPLE_W = 16;
    localparam int ENV_W    = 15;
    localparam int GAIN_W   = 17;
    localparam int CFG_W    = 17;
    localparam int IDX_W    = 3;

    // serial multiplier: multiplicand width, multiplier width, product width
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 17;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // serial divider: quotient bits, one per step
    localparam int DIV_Q_W   = 17;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W);

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'd65536;

    // register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [IDX_W-1:0] REG_INV_RATIO = 3'd1;
    localparam logic [IDX_W-1:0] REG_ATTACK    = 3'd2;
    localparam logic [IDX_W-1:0] REG_RELEASE   = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAKEUP    = 3'd4;

    // reset values of the registers
    localparam logic [14:0] THRESHOLD_RST = 15'd32767;
    localparam logic [16:0] INV_RATIO_RST = 17'd65536;
    localparam logic [15:0] ATTACK_RST    = 16'd65535;
    localparam logic [15:0] RELEASE_RST   = 16'd655;
    localparam logic [15:0] MAKEUP_RST    = 16'd4096;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       channel;
    } fpc_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       channel_out;
    } fpc_out_t;

endpackage

`default_nettype wire

// ===== rtl/fpc_smul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none

module fpc_smul import fpc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [MUL_A_W-1:0] a,
    input  wire logic [MUL_B_W-1:0] b,
    output logic                    busy,
    output logic                    done,
    output logic [MUL_P_W-1:0]      p
);

    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_A_W-1:0]   acc_reg;
    logic [MUL_B_W-1:0]   lo_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [MUL_A_W:0]     sum;

    // add the multiplicand when the current multiplier bit is set
    assign sum = {1'b0, acc_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg   <= a;
                lo_reg  <= b;
                acc_reg <= '0;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                acc_reg <= sum[MUL_A_W:1];
                lo_reg  <= {sum[0], lo_reg[MUL_B_W-1:1]};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_B_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = run_reg;
    assign done = done_reg;
    assign p    = {acc_reg, lo_reg};

endmodule

`default_nettype wire

// ===== rtl/fpc_sdiv.sv =====
// restoring divider for the gain, one quotient bit per cycle
`default_nettype none

module fpc_sdiv import fpc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [ENV_W:0]     target,
    input  wire logic [ENV_W-1:0]   divisor,
    output logic                    busy,
    output logic                    done,
    output logic [DIV_Q_W-1:0]      q
);

    logic [ENV_W-1:0]     rem_reg;
    logic [ENV_W-1:0]     dvs_reg;
    logic [DIV_Q_W-1:0]   q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [ENV_W:0]       trial;
    logic                 fits;
    logic [ENV_W:0]       diff;

    // q_reg shifts dividend bits out at the top and quotient bits in at the bottom
    assign trial = {rem_reg, q_reg[DIV_Q_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                // dividend is target shifted left by 16, target never above divisor
                rem_reg <= target[ENV_W:1];
                q_reg   <= {target[0], {(DIV_Q_W-1){1'b0}}};
                dvs_reg <= divisor;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                rem_reg <= fits ? diff[ENV_W-1:0] : trial[ENV_W-1:0];
                q_reg   <= {q_reg[DIV_Q_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_Q_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = run_reg;
    assign done = done_reg;
    assign q    = q_reg;

endmodule

`default_nettype wire

// ===== rtl/feedforward_peak_compressor.sv =====
// feedforward peak compressor top level: envelope, gain and output sequencer
//
//  port group  direction  handshake           payload
//  s_*         in         s_valid / s_ready   fpc_in_t  (sample_in, channel)
//  m_*         out        m_valid / m_ready   fpc_out_t (sample_out, channel_out)
//  cfg_*       in         cfg_wr_en only      cfg_index, cfg_data
//
// above the knee a transaction makes four multiplier passes and one divider pass,
// below it three multiplier passes
// s_ready is high only in idle, even while a finished result waits in the output register
// a stalled m_ready holds the sequencer in its final state until the output register frees up
// aresetn is synchronous, active low; it clears control, envelopes and registers
`default_nettype none

module feedforward_peak_compressor import fpc_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire fpc_in_t          s_data,

    output logic                  m_valid,
    input  wire logic             m_ready,
    output fpc_out_t              m_data,

    input  wire logic             cfg_wr_en,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENV_WAIT,
        S_ENV_UPD,
        S_GAIN_CHK,
        S_CMP_WAIT,
        S_DIV_WAIT,
        S_OUT1_WAIT,
        S_OUT2_WAIT,
        S_FIN
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [14:0] thr_reg;
    logic [16:0] ir_reg;
    logic [15:0] attack_reg;
    logic [15:0] release_reg;
    logic [15:0] makeup_reg;

    // per-channel peak envelopes
    logic [ENV_W-1:0] env_reg [CHANNELS];

    // transaction context
    logic             neg_reg;
    logic [16:0]      absval_reg;
    logic             ch_reg;
    logic [CH_W-1:0]  idx_reg;
    logic             rising_reg;
    logic [ENV_W-1:0] mag_reg;
    logic [ENV_W-1:0] env_old_reg;
    logic [ENV_W-1:0] step_reg;
    logic [ENV_W-1:0] env_new_reg;
    logic [15:0]      res_reg;

    // output register
    logic             m_valid_reg;
    fpc_out_t         m_data_reg;

    // serial unit controls, registered in the sequencer
    logic               mul_start_reg;
    logic [MUL_A_W-1:0] mul_a_reg;
    logic [MUL_B_W-1:0] mul_b_reg;
    logic               div_start_reg;
    logic [ENV_W:0]     div_target_reg;

    logic               mul_busy;
    logic               mul_done;
    logic [MUL_P_W-1:0] mul_p;
    logic               div_busy;
    logic               div_done;
    logic [DIV_Q_W-1:0] div_q;

    fpc_smul u_smul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .busy    (mul_busy),
        .done    (mul_done),
        .p       (mul_p)
    );

    fpc_sdiv u_sdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .target  (div_target_reg),
        .divisor (env_new_reg),
        .busy    (div_busy),
        .done    (div_done),
        .q       (div_q)
    );

    // input side: level, envelope distance and coefficient choice
    logic [CH_W-1:0]  in_idx;
    logic [16:0]      in_abs;
    logic [ENV_W-1:0] in_level;
    logic [ENV_W-1:0] in_env;
    logic             in_rising;
    logic [ENV_W-1:0] in_mag;
    logic [15:0]      in_coeff;

    always_comb begin
        in_idx    = (CHANNELS > 1) ? CH_W'(s_data.channel) : '0;
        in_abs    = s_data.sample_in[SAMPLE_W-1]
                    ? (17'h10000 - {1'b0, s_data.sample_in})
                    : {1'b0, s_data.sample_in};
        // full-scale negative saturates to 32767
        in_level  = (in_abs > 17'd32767) ? 15'h7FFF : in_abs[ENV_W-1:0];
        in_env    = env_reg[in_idx];
        in_rising = in_level > in_env;
        in_mag    = in_rising ? (in_level - in_env) : (in_env - in_level);
        in_coeff  = in_rising ? attack_reg : release_reg;
    end

    // rounded envelope step, clamped so the envelope never overshoots
    logic [17:0]      env_rnd;
    logic [ENV_W-1:0] env_step;
    assign env_rnd  = ({1'b0, mul_p[31:15]} + 18'd1) >> 1;
    assign env_step = (env_rnd > {3'b0, mag_reg}) ? mag_reg : env_rnd[ENV_W-1:0];

    logic [ENV_W-1:0] env_new;
    assign env_new = rising_reg ? (env_old_reg + step_reg) : (env_old_reg - step_reg);

    // inverse ratios above unity (ratios below 1:1) are held at 1:1
    logic [16:0] ir_clamp;
    assign ir_clamp = (ir_reg > GAIN_UNITY) ? GAIN_UNITY : ir_reg;

    // rounded compressed excess and the divider's target level
    logic [18:0]  comp_rnd;
    logic [ENV_W:0] target;
    assign comp_rnd = ({1'b0, mul_p[32:15]} + 19'd1) >> 1;
    assign target   = {1'b0, thr_reg} + {1'b0, comp_rnd[ENV_W-1:0]};

    // final rounding (half away from zero on the magnitude) and saturation
    logic [21:0] out_rnd;
    logic [16:0] neg_mag;
    logic [16:0] neg_wide;
    logic [15:0] out_res;
    always_comb begin
        out_rnd  = ({1'b0, mul_p[47:27]} + 22'd1) >> 1;
        neg_mag  = (out_rnd > 22'd32768) ? 17'd32768 : out_rnd[16:0];
        neg_wide = 17'h10000 - neg_mag;
        if (neg_reg) begin
            out_res = neg_wide[15:0];
        end else begin
            out_res = (out_rnd > 22'd32767) ? 16'h7FFF : out_rnd[15:0];
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= THRESHOLD_RST;
            ir_reg      <= INV_RATIO_RST;
            attack_reg  <= ATTACK_RST;
            release_reg <= RELEASE_RST;
            makeup_reg  <= MAKEUP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_THRESHOLD: thr_reg     <= cfg_data[14:0];
                REG_INV_RATIO: ir_reg      <= cfg_data[16:0];
                REG_ATTACK:    attack_reg  <= cfg_data[15:0];
                REG_RELEASE:   release_reg <= cfg_data[15:0];
                REG_MAKEUP:    makeup_reg  <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                env_reg[i] <= '0;
            end
        end else begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            // the final state reloads the output register on its own
            if (m_valid_reg && m_ready && (state_reg != S_FIN)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        neg_reg       <= s_data.sample_in[SAMPLE_W-1];
                        absval_reg    <= in_abs;
                        ch_reg        <= s_data.channel;
                        idx_reg       <= in_idx;
                        rising_reg    <= in_rising;
                        mag_reg       <= in_mag;
                        env_old_reg   <= in_env;
                        // distance times smoothing coefficient
                        mul_a_reg     <= MUL_A_W'(in_mag);
                        mul_b_reg     <= MUL_B_W'(in_coeff);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_ENV_WAIT;
                    end
                end
                S_ENV_WAIT: begin
                    if (mul_done) begin
                        step_reg  <= env_step;
                        state_reg <= S_ENV_UPD;
                    end
                end
                S_ENV_UPD: begin
                    env_reg[idx_reg] <= env_new;
                    env_new_reg      <= env_new;
                    state_reg        <= S_GAIN_CHK;
                end
                S_GAIN_CHK: begin
                    mul_start_reg <= 1'b1;
                    if (env_new_reg > thr_reg) begin
                        // excess over the knee times the inverse ratio
                        mul_a_reg <= MUL_A_W'(env_new_reg - thr_reg);
                        mul_b_reg <= ir_clamp;
                        state_reg <= S_CMP_WAIT;
                    end else begin
                        // unity gain below the knee
                        mul_a_reg <= MUL_A_W'(absval_reg);
                        mul_b_reg <= GAIN_UNITY;
                        state_reg <= S_OUT1_WAIT;
                    end
                end
                S_CMP_WAIT: begin
                    if (mul_done) begin
                        div_target_reg <= target;
                        div_start_reg  <= 1'b1;
                        state_reg      <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        mul_a_reg     <= MUL_A_W'(absval_reg);
                        mul_b_reg     <= div_q;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_OUT1_WAIT;
                    end
                end
                S_OUT1_WAIT: begin
                    if (mul_done) begin
                        // gained magnitude times makeup gain
                        mul_a_reg     <= mul_p[MUL_A_W-1:0];
                        mul_b_reg     <= MUL_B_W'(makeup_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_OUT2_WAIT;
                    end
                end
                S_OUT2_WAIT: begin
                    if (mul_done) begin
                        res_reg   <= out_res;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    // wait for the output register to free up
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.sample_out  <= res_reg;
                        m_data_reg.channel_out <= ch_reg;
                        m_valid_reg            <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // multiplier is never restarted while a pass is running
    a_mul_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start_reg |-> !mul_busy)
        else $error("multiplier started while busy");

    // no serial unit is still running once the sequencer is idle
    a_idle_units: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (!mul_busy && !div_busy))
        else $error("serial unit running in idle");

    // the gain never exceeds unity
    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (div_q <= GAIN_UNITY))
        else $error("gain above unity");

    // envelope step never overshoots the level
    a_step_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ENV_UPD) |-> (step_reg <= mag_reg))
        else $error("envelope step beyond distance");

endmodule

`default_nettype wire

// ===== dv/peak_compressor_checker.sv =====
// checker for the peak compressor: follows the channels, predicts each result and compares
module peak_compressor_checker import fpc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  fpc_in_t          s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  fpc_out_t         m_data,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               mismatch_count,
    output int               pending_count
);

    logic [ENV_W-1:0]  thr_reg;
    logic [GAIN_W-1:0] ratio_reg;
    logic [15:0]       attack_reg;
    logic [15:0]       release_reg;
    logic [15:0]       makeup_reg;
    logic [ENV_W-1:0]  env_level [CHANNELS];

    fpc_out_t predicted_samples[$];
    int       miss_total = 0;

    // updates the envelope of the item's channel and returns the compressed sample
    function automatic fpc_out_t compress_sample(fpc_in_t item);
        logic              neg;
        logic              rising;
        logic [16:0]       abs_val;
        logic [ENV_W-1:0]  level;
        logic [ENV_W-1:0]  env;
        logic [ENV_W-1:0]  diff;
        logic [15:0]       coeff;
        logic [GAIN_W-1:0] ratio;
        logic [GAIN_W-1:0] gain;
        logic [63:0]       step;
        logic [63:0]       comp;
        logic [63:0]       target;
        logic [63:0]       mag;
        logic [63:0]       rounded;
        int unsigned       slot;
        fpc_out_t          res;
        neg     = item.sample_in[SAMPLE_W-1];
        abs_val = neg ? 17'h10000 - {1'b0, item.sample_in} : {1'b0, item.sample_in};
        level   = (abs_val > 17'd32767) ? 15'h7fff : abs_val[ENV_W-1:0];
        slot    = int'(item.channel) % CHANNELS;
        env     = env_level[slot];
        rising  = level > env;
        coeff   = rising ? attack_reg : release_reg;
        diff    = rising ? level - env : env - level;
        step    = (64'(diff) * 64'(coeff) + 64'd32768) >> 16;
        if (step > 64'(diff)) begin
            step = 64'(diff);
        end
        env = rising ? env + step[ENV_W-1:0] : env - step[ENV_W-1:0];
        env_level[slot] = env;

        if (env <= thr_reg || env == '0) begin
            gain = GAIN_UNITY;
        end else begin
            ratio  = (ratio_reg > GAIN_UNITY) ? GAIN_UNITY : ratio_reg;
            comp   = (64'(env - thr_reg) * 64'(ratio) + 64'd32768) >> 16;
            target = 64'(thr_reg) + comp;
            gain   = GAIN_W'((target << 16) / 64'(env));
        end

        mag     = 64'(abs_val) * 64'(gain) * 64'(makeup_reg);
        rounded = (mag + (64'd1 << 27)) >> 28;
        if (neg) begin
            if (rounded > 64'd32768) begin
                rounded = 64'd32768;
            end
            res.sample_out = SAMPLE_W'(17'h10000 - rounded[16:0]);
        end else begin
            if (rounded > 64'd32767) begin
                rounded = 64'd32767;
            end
            res.sample_out = rounded[SAMPLE_W-1:0];
        end
        res.channel_out = item.channel;
        return res;
    endfunction

    always @(posedge aclk) begin
        fpc_out_t want;
        if (!aresetn) begin
            thr_reg     = THRESHOLD_RST;
            ratio_reg   = INV_RATIO_RST;
            attack_reg  = ATTACK_RST;
            release_reg = RELEASE_RST;
            makeup_reg  = MAKEUP_RST;
            for (int i = 0; i < CHANNELS; i++) begin
                env_level[i] = '0;
            end
            predicted_samples.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_THRESHOLD: thr_reg     = cfg_data[ENV_W-1:0];
                    REG_INV_RATIO: ratio_reg   = cfg_data[GAIN_W-1:0];
                    REG_ATTACK:    attack_reg  = cfg_data[15:0];
                    REG_RELEASE:   release_reg = cfg_data[15:0];
                    REG_MAKEUP:    makeup_reg  = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predicted_samples.push_back(compress_sample(s_data));
            end
            if (m_valid && m_ready) begin
                if (predicted_samples.size() == 0) begin
                    miss_total++;
                    if (miss_total <= 10) begin
                        $display("unexpected result: sample %0d ch %0d",
                                 m_data.sample_out, m_data.channel_out);
                    end
                end else begin
                    want = predicted_samples.pop_front();
                    if (m_data.sample_out !== want.sample_out ||
                        m_data.channel_out !== want.channel_out) begin
                        miss_total++;
                        if (miss_total <= 10) begin
                            $display("mismatch: expected sample %0d ch %0d, got sample %0d ch %0d",
                                     want.sample_out, want.channel_out,
                                     m_data.sample_out, m_data.channel_out);
                        end
                    end
                end
            end
        end
        pending_count  <= predicted_samples.size();
        mismatch_count <= miss_total;
    end

endmodule

// ===== dv/tb_feedforward_peak_compressor.sv =====
// testbench top for the feedforward peak compressor: stimulus, settings and verdict
module tb_feedforward_peak_compressor;
    import fpc_pkg::*;

    // cycles without any transaction before the run is declared hung
    localparam int IDLE_LIMIT = 4000;
    // receiver hold-off long enough to back the block up into its input
    localparam int HOLD_OFF   = 600;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    fpc_in_t          s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    fpc_out_t         m_data;
    logic             cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data  = '0;

    int mismatch_count;
    int pending_count;
    int samples_sent  = 0;
    int results_taken = 0;
    int idle_cycles   = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    feedforward_peak_compressor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    peak_compressor_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // hang detection: any accepted transaction on either channel clears the count
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // result sink: random stalls, a zero-stall stretch every third hundred results,
    // and two long hold-offs so the block fills and drops s_ready
    initial begin : result_sink
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (results_taken == 150 || results_taken == 900) begin
                stall = HOLD_OFF;
            end else if ((results_taken / 100) % 3 == 2) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 14);
            end
            // lowering ready only when a stall is drawn keeps one assignment per step
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_taken++;
        end
    end

    function automatic fpc_in_t pack_sample(int value, bit ch);
        fpc_in_t item;
        item.sample_in = SAMPLE_W'(value);
        item.channel   = ch;
        return item;
    endfunction

    // random sample: full range, quiet, extremes, or near the current knee
    function automatic fpc_in_t random_sample(int knee);
        int pick;
        int value;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            value = int'($urandom_range(0, 65535)) - 32768;
        end else if (pick < 6) begin
            value = int'($urandom_range(0, 2047)) - 1024;
        end else if (pick == 6) begin
            case ($urandom_range(0, 5))
                0: value = -32768;
                1: value = 32767;
                2: value = -32767;
                3: value = 0;
                4: value = 1;
                default: value = -1;
            endcase
        end else begin
            value = knee + int'($urandom_range(0, 1024)) - 512;
            if (value > 32767) value = 32767;
            if (value < 0) value = 0;
            if ($urandom_range(0, 1) == 1) value = -value;
        end
        return pack_sample(value, 1'($urandom_range(0, 1)));
    endfunction

    // one input transaction; every fourth run of 64 goes back to back
    task automatic send_sample(input fpc_in_t item);
        int gap;
        gap = ((samples_sent / 64) % 4 == 3) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    // wait until every predicted result has come back; the checker's count is registered
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    // full register set, then junk writes to the unused indexes, which must be ignored
    task automatic write_settings(input int thr, input int ratio, input int atk,
                                  input int rel, input int mk);
        cfg_wr_en <= 1'b1;
        put_reg(REG_THRESHOLD, CFG_W'(thr));
        put_reg(REG_INV_RATIO, CFG_W'(ratio));
        put_reg(REG_ATTACK,    CFG_W'(atk));
        put_reg(REG_RELEASE,   CFG_W'(rel));
        put_reg(REG_MAKEUP,    CFG_W'(mk));
        for (int i = int'(REG_MAKEUP) + 1; i < (1 << IDX_W); i++) begin
            put_reg(IDX_W'(i), CFG_W'($urandom_range(0, 131071)));
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int count, input int knee);
        for (int i = 0; i < count; i++) begin
            send_sample(random_sample(knee));
        end
        wait_drained();
    endtask

    initial begin : stimulus
        int thr;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: threshold at full scale, unity makeup, output follows input
        send_sample(pack_sample(0, 1'b0));
        send_sample(pack_sample(32767, 1'b0));
        send_sample(pack_sample(-32768, 1'b1));
        send_sample(pack_sample(-1, 1'b1));
        send_sample(pack_sample(1, 1'b0));
        wait_drained();

        // 4:1 above a low knee, instant attack, slow release
        write_settings(8192, 16384, 65535, 655, 4096);
        send_sample(pack_sample(32767, 1'b0));
        send_sample(pack_sample(-32768, 1'b0));
        send_sample(pack_sample(100, 1'b0));
        send_sample(pack_sample(0, 1'b1));
        send_sample(pack_sample(20000, 1'b1));
        send_sample(pack_sample(-20000, 1'b1));
        send_sample(pack_sample(8192, 1'b0));
        wait_drained();

        // frozen envelopes, ratio register above 1:1, makeup at maximum for saturation
        write_settings(4096, 131071, 0, 0, 65535);
        send_sample(pack_sample(32767, 1'b0));
        send_sample(pack_sample(-32768, 1'b1));
        send_sample(pack_sample(1000, 1'b0));
        send_sample(pack_sample(-1, 1'b1));
        send_sample(pack_sample(16384, 1'b0));
        wait_drained();

        // zero threshold and zero inverse ratio: hard limiter, half-speed attack, fastest release
        write_settings(0, 0, 32768, 65535, 8192);
        send_sample(pack_sample(12345, 1'b0));
        send_sample(pack_sample(-32768, 1'b0));
        send_sample(pack_sample(1, 1'b0));
        send_sample(pack_sample(-5, 1'b1));
        send_sample(pack_sample(32767, 1'b1));
        wait_drained();

        // extreme settings with random program material
        write_settings(0, 0, 0, 65535, 65535);
        run_random(100, 0);
        write_settings(32767, 65536, 65535, 0, 0);
        run_random(100, 32767);

        // random settings, ratio register over its whole width
        for (int phase = 0; phase < 13; phase++) begin
            thr = $urandom_range(0, 32767);
            write_settings(thr, $urandom_range(0, 131071), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 65535));
            run_random(100, thr);
        end

        // let any stray result show up before the verdict
        repeat (300) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
